// File: rtl/isdm_pkg.sv
// ---------------------------------------------------------------------------
// isdm_pkg: shared types and constants
// Field widths, lattice size, trial codes and the structs that pass between
// the lattice, the energy core and the statistics block.
// ---------------------------------------------------------------------------
package isdm_pkg;

	localparam int COORD_W = 3;   // site coordinate field
	localparam int DE_W    = 5;   // flip energy, signed
	localparam int E_W     = 9;   // system energy, signed
	localparam int D_W     = 9;   // demon energy, unsigned
	localparam int M_W     = 8;   // magnetization, signed
	localparam int SWEEP_W = 32;  // sweep counter

	// lattice side; the energy and magnetization widths above are sized for it
	localparam int LATTICE_SIDE = 8;
	localparam int SITES        = LATTICE_SIDE * LATTICE_SIDE;

	typedef enum logic {
		CMD_DEMON = 1'b0,
		CMD_HEAT  = 1'b1
	} cmd_t;

	// spin of the trial site and number of its four neighbors that point down
	typedef struct packed {
		logic       self_down;
		logic [2:0] nbr_down;
	} lat_rd_t;

	typedef struct packed {
		logic signed [E_W-1:0] energy;
		logic        [D_W-1:0] demon_e;
		logic signed [M_W-1:0] magnet;
	} state_t;

	typedef struct packed {
		logic                   flip;
		logic                   demon_trial;
		logic signed [DE_W-1:0] de;
		state_t                 nxt;
	} upd_t;

endpackage

// File: rtl/isdm_lattice.sv
// ---------------------------------------------------------------------------
// isdm_lattice: periodic spin lattice
// Holds one down flag per site, reads the trial site and its four wrapped
// neighbors, and toggles the trial site on a flip.
// ---------------------------------------------------------------------------
module isdm_lattice (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [isdm_pkg::COORD_W-1:0]  site_row,
	input  logic [isdm_pkg::COORD_W-1:0]  site_col,
	input  logic                          flip_en,
	output isdm_pkg::lat_rd_t             rd
);

	localparam int RW        = $clog2(isdm_pkg::LATTICE_SIDE);
	localparam int CW        = (RW > isdm_pkg::COORD_W) ? RW : isdm_pkg::COORD_W;
	localparam int MOD_STEPS = ((1 << isdm_pkg::COORD_W) - 1) / isdm_pkg::LATTICE_SIDE;

	// coordinate modulo the side, by repeated compare and subtract
	function automatic logic [RW-1:0] wrap_coord(input logic [isdm_pkg::COORD_W-1:0] v);
		logic [CW-1:0] t;
		t = CW'(v);
		for (int i = 0; i < MOD_STEPS; i++) begin
			if (t >= CW'(isdm_pkg::LATTICE_SIDE)) begin
				t = t - CW'(isdm_pkg::LATTICE_SIDE);
			end
		end
		return t[RW-1:0];
	endfunction

	function automatic logic [RW-1:0] inc_wrap(input logic [RW-1:0] v);
		return (v == RW'(isdm_pkg::LATTICE_SIDE - 1)) ? '0 : v + 1'b1;
	endfunction

	function automatic logic [RW-1:0] dec_wrap(input logic [RW-1:0] v);
		return (v == '0) ? RW'(isdm_pkg::LATTICE_SIDE - 1) : v - 1'b1;
	endfunction

	logic [isdm_pkg::LATTICE_SIDE-1:0] down_q [isdm_pkg::LATTICE_SIDE];
	logic [RW-1:0]                     r, c, rm1, rp1, cm1, cp1;
	logic                              n_up, n_dn, n_lf, n_rt;

	assign r   = wrap_coord(site_row);
	assign c   = wrap_coord(site_col);
	assign rm1 = dec_wrap(r);
	assign rp1 = inc_wrap(r);
	assign cm1 = dec_wrap(c);
	assign cp1 = inc_wrap(c);

	assign n_up = down_q[rm1][c];
	assign n_dn = down_q[rp1][c];
	assign n_lf = down_q[r][cm1];
	assign n_rt = down_q[r][cp1];

	assign rd.self_down = down_q[r][c];
	assign rd.nbr_down  = {2'b00, n_up} + {2'b00, n_dn} + {2'b00, n_lf} + {2'b00, n_rt};

	// all spins up after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < isdm_pkg::LATTICE_SIDE; i++) begin
				down_q[i] <= '0;
			end
		end else if (flip_en) begin
			down_q[r][c] <= ~down_q[r][c];
		end
	end

endmodule

// File: rtl/isdm_core.sv
// ---------------------------------------------------------------------------
// isdm_core: flip energy and acceptance
// Forms the flip energy, decides demon and heat-up trials, and holds the
// system energy, demon energy and magnetization.
// ---------------------------------------------------------------------------
module isdm_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                adv,
	input  logic                                heat,
	input  isdm_pkg::lat_rd_t                   rd,
	input  logic signed [isdm_pkg::E_W-1:0]     target,
	output isdm_pkg::upd_t                      upd,
	output isdm_pkg::state_t                    st
);

	localparam int DE_XW = isdm_pkg::DE_W + 1;
	localparam int DN_W  = isdm_pkg::D_W + 2;

	isdm_pkg::state_t           st_q;
	logic signed [DE_XW-1:0]    de_up;
	logic signed [DE_XW-1:0]    de_x;
	logic signed [isdm_pkg::DE_W-1:0] de;
	logic signed [DN_W-1:0]     dnew;
	logic                       demon_ok, heat_ok, flip;

	// energy of flipping an up spin: 2 * (4 - 2 * down neighbors)
	assign de_up = DE_XW'(8) - $signed({1'b0, rd.nbr_down, 2'b00});
	assign de_x  = rd.self_down ? -de_up : de_up;
	assign de    = de_x[isdm_pkg::DE_W-1:0];

	assign dnew     = $signed({2'b00, st_q.demon_e}) - DN_W'(de);
	assign demon_ok = (dnew[DN_W-1:isdm_pkg::D_W] == 2'b00);
	assign heat_ok  = (de > 0) && (st_q.energy < target);
	assign flip     = heat ? heat_ok : demon_ok;

	always_comb begin
		upd             = '0;
		upd.flip        = flip;
		upd.demon_trial = !heat;
		upd.de          = de;
		upd.nxt         = st_q;
		if (flip) begin
			upd.nxt.energy = st_q.energy + isdm_pkg::E_W'(de);
			upd.nxt.magnet = rd.self_down ? st_q.magnet + isdm_pkg::M_W'(2)
			                              : st_q.magnet - isdm_pkg::M_W'(2);
			if (!heat) begin
				upd.nxt.demon_e = dnew[isdm_pkg::D_W-1:0];
			end
		end
	end

	assign st = st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.energy  <= isdm_pkg::E_W'(-2 * isdm_pkg::SITES);
			st_q.demon_e <= '0;
			st_q.magnet  <= isdm_pkg::M_W'(isdm_pkg::SITES);
		end else if (adv) begin
			st_q <= upd.nxt;
		end
	end

endmodule

// File: rtl/isdm_stats.sv
// ---------------------------------------------------------------------------
// isdm_stats: counters and running sums
// Accepted moves, sweeps and saturating sums over demon trials.
// ---------------------------------------------------------------------------
module isdm_stats #(
	parameter int SUM_WIDTH    = 48
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 adv,
	input  isdm_pkg::upd_t                       upd,
	output logic [SUM_WIDTH-1:0]                 accepted_count,
	output logic [isdm_pkg::SWEEP_W-1:0]         sweeps_done,
	output logic signed [SUM_WIDTH-1:0]          energy_sum,
	output logic [SUM_WIDTH-1:0]                 demon_sum,
	output logic signed [SUM_WIDTH-1:0]          magnet_sum,
	output logic [SUM_WIDTH-1:0]                 magnet_sq_sum
);

	localparam int TW    = $clog2(isdm_pkg::SITES);
	localparam int SQ_W  = 2 * isdm_pkg::M_W;

	function automatic logic [SUM_WIDTH-1:0] add_u_sat(input logic [SUM_WIDTH-1:0] a,
	                                                   input logic [SUM_WIDTH-1:0] b);
		logic [SUM_WIDTH:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[SUM_WIDTH] ? '1 : s[SUM_WIDTH-1:0];
	endfunction

	function automatic logic [SUM_WIDTH-1:0] add_s_sat(input logic [SUM_WIDTH-1:0] a,
	                                                   input logic [SUM_WIDTH-1:0] b);
		logic [SUM_WIDTH:0] s;
		s = {a[SUM_WIDTH-1], a} + {b[SUM_WIDTH-1], b};
		if (s[SUM_WIDTH] != s[SUM_WIDTH-1]) begin
			return s[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
			                    : {1'b0, {(SUM_WIDTH-1){1'b1}}};
		end
		return s[SUM_WIDTH-1:0];
	endfunction

	logic [SUM_WIDTH-1:0]         acc_q, esum_q, dsum_q, msum_q, sqsum_q;
	logic [isdm_pkg::SWEEP_W-1:0] sweep_q;
	logic [TW-1:0]                trial_q;
	logic signed [SQ_W-1:0]       m_sq;

	assign m_sq = upd.nxt.magnet * upd.nxt.magnet;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			esum_q  <= '0;
			dsum_q  <= '0;
			msum_q  <= '0;
			sqsum_q <= '0;
			sweep_q <= '0;
			trial_q <= '0;
		end else if (adv && upd.demon_trial) begin
			if (upd.flip) begin
				acc_q <= add_u_sat(acc_q, SUM_WIDTH'(1));
			end
			esum_q  <= add_s_sat(esum_q, SUM_WIDTH'(upd.nxt.energy));
			dsum_q  <= add_u_sat(dsum_q, SUM_WIDTH'(upd.nxt.demon_e));
			msum_q  <= add_s_sat(msum_q, SUM_WIDTH'(upd.nxt.magnet));
			sqsum_q <= add_u_sat(sqsum_q, SUM_WIDTH'(unsigned'(m_sq)));
			// close a sweep after N demon trials
			if (trial_q == TW'(isdm_pkg::SITES - 1)) begin
				trial_q <= '0;
				if (sweep_q != '1) begin
					sweep_q <= sweep_q + 1'b1;
				end
			end else begin
				trial_q <= trial_q + 1'b1;
			end
		end
	end

	assign accepted_count = acc_q;
	assign sweeps_done    = sweep_q;
	assign energy_sum     = esum_q;
	assign demon_sum      = dsum_q;
	assign magnet_sum     = msum_q;
	assign magnet_sq_sum  = sqsum_q;

endmodule

// File: rtl/ising_demon_spin_update.sv
// ---------------------------------------------------------------------------
// ising_demon_spin_update: Creutz demon spin update for a 2D Ising lattice
// Takes one trial site per request, decides the flip from the four wrapped
// neighbors and reports energies, magnetization, counters and sums.
// ---------------------------------------------------------------------------
//
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------------------
//  in       | in_valid / in_stall   | cmd, site_row, site_col
//  out      | out_valid / out_stall | flipped, delta_energy, energy_now,
//           |                       | demon_now, magnet_now, accepted_count,
//           |                       | sweeps_done, energy_sum, demon_sum,
//           |                       | magnet_sum, magnet_sq_sum
//  cfg      | cfg_wr_en             | cfg_wr_data (target energy)
//
//  One request per cycle while out_stall is low; each result passes the
//  input register, then lattice read, flip decision and state update.
//  Lattice read, flip decision and sum update in the same cycle set that rate.
//  Reset: all spins up, energy -2N, magnetization N, demon and sums zero.
//  out_stall holds the result; in_stall rises only when both stages are full.
// ---------------------------------------------------------------------------
module ising_demon_spin_update #(
	parameter int SUM_WIDTH    = 48
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration
	input  logic                                 cfg_wr_en,
	input  logic signed [isdm_pkg::E_W-1:0]      cfg_wr_data,
	// requests
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 cmd,
	input  logic [isdm_pkg::COORD_W-1:0]         site_row,
	input  logic [isdm_pkg::COORD_W-1:0]         site_col,
	// results
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 flipped,
	output logic signed [isdm_pkg::DE_W-1:0]     delta_energy,
	output logic signed [isdm_pkg::E_W-1:0]      energy_now,
	output logic [isdm_pkg::D_W-1:0]             demon_now,
	output logic signed [isdm_pkg::M_W-1:0]      magnet_now,
	output logic [SUM_WIDTH-1:0]                 accepted_count,
	output logic [isdm_pkg::SWEEP_W-1:0]         sweeps_done,
	output logic signed [SUM_WIDTH-1:0]          energy_sum,
	output logic [SUM_WIDTH-1:0]                 demon_sum,
	output logic signed [SUM_WIDTH-1:0]          magnet_sum,
	output logic [SUM_WIDTH-1:0]                 magnet_sq_sum
);

	logic                                 valid_s1;
	logic                                 cmd_s1;
	logic [isdm_pkg::COORD_W-1:0]         row_s1, col_s1;
	logic                                 valid_s2;
	logic                                 flip_s2;
	logic signed [isdm_pkg::DE_W-1:0]     de_s2;
	logic signed [isdm_pkg::E_W-1:0]      target_q;
	logic                                 adv;
	isdm_pkg::lat_rd_t                    lat_rd;
	isdm_pkg::upd_t                       upd;
	isdm_pkg::state_t                     st;

	// advance the held request whenever the result slot is free or drains now;
	// the state registers change only on advance, so they double as the
	// held result fields
	assign adv      = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && valid_s2 && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else if (cfg_wr_en) begin
			target_q <= cfg_wr_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cmd_s1 <= cmd;
			row_s1 <= site_row;
			col_s1 <= site_col;
		end
	end

	isdm_lattice u_lattice (
		.clk     (clk),
		.arst_n  (arst_n),
		.site_row(row_s1),
		.site_col(col_s1),
		.flip_en (adv && upd.flip),
		.rd      (lat_rd)
	);

	isdm_core u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.adv   (adv),
		.heat  (cmd_s1 == isdm_pkg::CMD_HEAT),
		.rd    (lat_rd),
		.target(target_q),
		.upd   (upd),
		.st    (st)
	);

	isdm_stats #(
		.SUM_WIDTH   (SUM_WIDTH)
	) u_stats (
		.clk           (clk),
		.arst_n        (arst_n),
		.adv           (adv),
		.upd           (upd),
		.accepted_count(accepted_count),
		.sweeps_done   (sweeps_done),
		.energy_sum    (energy_sum),
		.demon_sum     (demon_sum),
		.magnet_sum    (magnet_sum),
		.magnet_sq_sum (magnet_sq_sum)
	);

	// result register: valid, flip flag and flip energy; drop valid on drain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			flip_s2 <= upd.flip;
			de_s2   <= upd.de;
		end
	end

	assign out_valid    = valid_s2;
	assign flipped      = flip_s2;
	assign delta_energy = de_s2;
	assign energy_now   = st.energy;
	assign demon_now    = st.demon_e;
	assign magnet_now   = st.magnet;

endmodule

// File: rtl/isdm_chk.sv
// ---------------------------------------------------------------------------
// isdm_chk: port-level checks
// Watches the result channel of the spin update block over time.
// ---------------------------------------------------------------------------
module isdm_chk #(
	parameter int SUM_WIDTH    = 48
) (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 out_valid,
	input logic                                 out_stall,
	input logic                                 flipped,
	input logic signed [isdm_pkg::DE_W-1:0]     delta_energy,
	input logic signed [isdm_pkg::E_W-1:0]      energy_now,
	input logic [SUM_WIDTH-1:0]                 accepted_count,
	input logic [isdm_pkg::SWEEP_W-1:0]         sweeps_done
);

	localparam logic [isdm_pkg::E_W-1:0] E0 = isdm_pkg::E_W'(-2 * isdm_pkg::SITES);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(flipped) && $stable(energy_now))
		else $error("result changed while stalled");

	// every flip moves the energy by a multiple of four
	a_energy_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> delta_energy[1:0] == 2'b00 && energy_now[1:0] == E0[1:0])
		else $error("energy off its lattice of values");

	// accepted moves advance by at most one per cycle
	a_acc_step: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> accepted_count == $past(accepted_count) ||
		                  accepted_count == $past(accepted_count) + 1'b1)
		else $error("accepted count jumped");

	// sweep count never goes back
	a_sweep_mono: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> sweeps_done >= $past(sweeps_done))
		else $error("sweep count decreased");

endmodule

bind ising_demon_spin_update isdm_chk #(
	.SUM_WIDTH   (SUM_WIDTH)
) u_isdm_chk (.*);

// File: dv/isdm_flip_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// isdm_flip_checker: result checker for the demon spin update
// Keeps its own lattice and statistics, predicts the result of each accepted
// trial request and compares every accepted result with the oldest prediction.
// ---------------------------------------------------------------------------
module isdm_flip_checker #(
	parameter int SUM_WIDTH = 48
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic signed [isdm_pkg::E_W-1:0]      cfg_wr_data,
	input  logic                                 in_valid,
	input  logic                                 in_stall,
	input  logic                                 cmd,
	input  logic [isdm_pkg::COORD_W-1:0]         site_row,
	input  logic [isdm_pkg::COORD_W-1:0]         site_col,
	input  logic                                 out_valid,
	input  logic                                 out_stall,
	input  logic                                 flipped,
	input  logic signed [isdm_pkg::DE_W-1:0]     delta_energy,
	input  logic signed [isdm_pkg::E_W-1:0]      energy_now,
	input  logic [isdm_pkg::D_W-1:0]             demon_now,
	input  logic signed [isdm_pkg::M_W-1:0]      magnet_now,
	input  logic [SUM_WIDTH-1:0]                 accepted_count,
	input  logic [isdm_pkg::SWEEP_W-1:0]         sweeps_done,
	input  logic signed [SUM_WIDTH-1:0]          energy_sum,
	input  logic [SUM_WIDTH-1:0]                 demon_sum,
	input  logic signed [SUM_WIDTH-1:0]          magnet_sum,
	input  logic [SUM_WIDTH-1:0]                 magnet_sq_sum,
	output int                                   open_requests,
	output int                                   fault_count
);

	import isdm_pkg::*;

	localparam int SITES     = 64;
	localparam int DEMON_TOP = 511;
	localparam longint unsigned UMAX = (SUM_WIDTH == 64) ? '1 : ((64'd1 << SUM_WIDTH) - 64'd1);
	localparam longint SMAX = longint'((64'd1 << (SUM_WIDTH - 1)) - 64'd1);
	localparam longint SMIN = -SMAX - 1;

	typedef struct packed {
		logic                        flip;
		logic signed [DE_W-1:0]      de;
		logic signed [E_W-1:0]       energy;
		logic        [D_W-1:0]       demon;
		logic signed [M_W-1:0]       magnet;
		logic        [SUM_WIDTH-1:0] accepts;
		logic        [SWEEP_W-1:0]   sweeps;
		logic signed [SUM_WIDTH-1:0] e_sum;
		logic        [SUM_WIDTH-1:0] d_sum;
		logic signed [SUM_WIDTH-1:0] m_sum;
		logic        [SUM_WIDTH-1:0] msq_sum;
	} trial_result_t;

	// shadow lattice and statistics
	logic [SITES-1:0] spin_down;
	int               sys_e;
	int               demon_e;
	int               mag;
	int               target_e;
	int               trial_idx;
	int unsigned      sweep_cnt;
	longint unsigned  accept_cnt;
	longint unsigned  demon_acc;
	longint unsigned  msq_acc;
	longint           energy_acc;
	longint           mag_acc;

	trial_result_t expected_updates[$];
	int            faults;

	function automatic longint unsigned add_usat(longint unsigned a, longint unsigned b);
		if (a > UMAX || b > UMAX - a)
			return UMAX;
		return a + b;
	endfunction

	function automatic longint add_ssat(longint a, longint b);
		if (b > 0 && a > SMAX - b)
			return SMAX;
		if (b < 0 && a < SMIN - b)
			return SMIN;
		return a + b;
	endfunction

	function automatic int spin_of(logic [2:0] r, logic [2:0] k);
		return spin_down[{r, k}] ? -1 : 1;
	endfunction

	// Decide the flip, update the shadow state and return the result it causes.
	function automatic trial_result_t predict_trial(logic c, logic [2:0] r, logic [2:0] k);
		logic [2:0]    r_n, r_s, k_e, k_w;
		int            s, nsum, de;
		logic          heat, flip;
		longint        m;
		trial_result_t res;
		heat = (c == CMD_HEAT);
		// coordinates wrap at the lattice edge
		r_n = r - 3'd1;
		r_s = r + 3'd1;
		k_e = k + 3'd1;
		k_w = k - 3'd1;
		s = spin_of(r, k);
		nsum = spin_of(r_n, k) + spin_of(r_s, k) + spin_of(r, k_e) + spin_of(r, k_w);
		de = 2 * s * nsum;
		if (heat)
			flip = (de > 0) && (sys_e < target_e);
		else
			flip = (de <= demon_e) && (demon_e - de <= DEMON_TOP);
		if (flip) begin
			spin_down[{r, k}] = ~spin_down[{r, k}];
			sys_e += de;
			mag += -2 * s;
			if (!heat) begin
				demon_e -= de;
				accept_cnt = add_usat(accept_cnt, 64'd1);
			end
		end
		if (!heat) begin
			m = mag;
			energy_acc = add_ssat(energy_acc, longint'(sys_e));
			demon_acc  = add_usat(demon_acc, longint'(demon_e));
			mag_acc    = add_ssat(mag_acc, m);
			msq_acc    = add_usat(msq_acc, m * m);
			trial_idx++;
			if (trial_idx >= SITES) begin
				trial_idx = 0;
				if (sweep_cnt != 32'hFFFF_FFFF)
					sweep_cnt++;
			end
		end
		res.flip    = flip;
		res.de      = de[DE_W-1:0];
		res.energy  = sys_e[E_W-1:0];
		res.demon   = demon_e[D_W-1:0];
		res.magnet  = mag[M_W-1:0];
		res.accepts = accept_cnt[SUM_WIDTH-1:0];
		res.sweeps  = sweep_cnt;
		res.e_sum   = energy_acc[SUM_WIDTH-1:0];
		res.d_sum   = demon_acc[SUM_WIDTH-1:0];
		res.m_sum   = mag_acc[SUM_WIDTH-1:0];
		res.msq_sum = msq_acc[SUM_WIDTH-1:0];
		return res;
	endfunction

	task automatic check_field(string name, longint exp_v, longint act_v);
		if (exp_v !== act_v) begin
			$display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
			faults++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spin_down  = '0;
			sys_e      = -2 * SITES;
			demon_e    = 0;
			mag        = SITES;
			target_e   = 0;
			trial_idx  = 0;
			sweep_cnt  = 0;
			accept_cnt = 0;
			demon_acc  = 0;
			msq_acc    = 0;
			energy_acc = 0;
			mag_acc    = 0;
			faults     = 0;
			expected_updates.delete();
			open_requests <= 0;
			fault_count   <= 0;
		end else begin
			if (cfg_wr_en)
				target_e = int'(cfg_wr_data);
			// retire the result first, so a request accepted on this edge is not matched
			if (out_valid && !out_stall) begin
				if (expected_updates.size() == 0) begin
					$display("%0t ns: result with no request pending, expected none actual energy %0d",
						$time, energy_now);
					faults++;
				end else begin
					trial_result_t exp_r;
					exp_r = expected_updates.pop_front();
					check_field("flipped",        longint'(exp_r.flip),    longint'(flipped));
					check_field("delta_energy",   longint'(exp_r.de),      longint'(delta_energy));
					check_field("energy_now",     longint'(exp_r.energy),  longint'(energy_now));
					check_field("demon_now",      longint'(exp_r.demon),   longint'(demon_now));
					check_field("magnet_now",     longint'(exp_r.magnet),  longint'(magnet_now));
					check_field("accepted_count", longint'(exp_r.accepts), longint'(accepted_count));
					check_field("sweeps_done",    longint'(exp_r.sweeps),  longint'(sweeps_done));
					check_field("energy_sum",     longint'(exp_r.e_sum),   longint'(energy_sum));
					check_field("demon_sum",      longint'(exp_r.d_sum),   longint'(demon_sum));
					check_field("magnet_sum",     longint'(exp_r.m_sum),   longint'(magnet_sum));
					check_field("magnet_sq_sum",  longint'(exp_r.msq_sum), longint'(magnet_sq_sum));
				end
			end
			if (in_valid && !in_stall)
				expected_updates.push_back(predict_trial(cmd, site_row, site_col));
			open_requests <= expected_updates.size();
			fault_count   <= faults;
		end
	end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: stimulus and verdict for ising_demon_spin_update
// Drives directed and random trial requests under several target energies
// and idling patterns; the checker beside the block predicts and compares.
// ---------------------------------------------------------------------------
module testbench;

	import isdm_pkg::*;

	localparam int  SUM_WIDTH   = 48;
	localparam time HALF_PERIOD = 4ns;
	localparam int  PHASES      = 8;
	localparam int  PHASE_REQS  = 235;

	logic                        clk         = 1'b0;
	logic                        arst_n      = 1'b0;
	logic                        cfg_wr_en   = 1'b0;
	logic signed [E_W-1:0]       cfg_wr_data = '0;
	logic                        in_valid    = 1'b0;
	logic                        in_stall;
	logic                        cmd         = CMD_DEMON;
	logic [COORD_W-1:0]          site_row    = '0;
	logic [COORD_W-1:0]          site_col    = '0;
	logic                        out_valid;
	logic                        out_stall   = 1'b0;
	logic                        flipped;
	logic signed [DE_W-1:0]      delta_energy;
	logic signed [E_W-1:0]       energy_now;
	logic [D_W-1:0]              demon_now;
	logic signed [M_W-1:0]       magnet_now;
	logic [SUM_WIDTH-1:0]        accepted_count;
	logic [SWEEP_W-1:0]          sweeps_done;
	logic signed [SUM_WIDTH-1:0] energy_sum;
	logic [SUM_WIDTH-1:0]        demon_sum;
	logic signed [SUM_WIDTH-1:0] magnet_sum;
	logic [SUM_WIDTH-1:0]        magnet_sq_sum;

	int open_requests;
	int fault_count;
	// idling odds in percent, changed only while the block is drained
	int send_gap_pct = 0;
	int stall_pct    = 0;

	always #(HALF_PERIOD) clk = ~clk;

	ising_demon_spin_update #(
		.SUM_WIDTH    (SUM_WIDTH)
	) u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cmd            (cmd),
		.site_row       (site_row),
		.site_col       (site_col),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.flipped        (flipped),
		.delta_energy   (delta_energy),
		.energy_now     (energy_now),
		.demon_now      (demon_now),
		.magnet_now     (magnet_now),
		.accepted_count (accepted_count),
		.sweeps_done    (sweeps_done),
		.energy_sum     (energy_sum),
		.demon_sum      (demon_sum),
		.magnet_sum     (magnet_sum),
		.magnet_sq_sum  (magnet_sq_sum)
	);

	isdm_flip_checker #(
		.SUM_WIDTH (SUM_WIDTH)
	) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cmd            (cmd),
		.site_row       (site_row),
		.site_col       (site_col),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.flipped        (flipped),
		.delta_energy   (delta_energy),
		.energy_now     (energy_now),
		.demon_now      (demon_now),
		.magnet_now     (magnet_now),
		.accepted_count (accepted_count),
		.sweeps_done    (sweeps_done),
		.energy_sum     (energy_sum),
		.demon_sum      (demon_sum),
		.magnet_sum     (magnet_sum),
		.magnet_sq_sum  (magnet_sq_sum),
		.open_requests  (open_requests),
		.fault_count    (fault_count)
	);

	// Stall the result side at random; one assignment per edge.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Offer one trial request, after a random gap, and hold it until accepted.
	// Leave in_valid high afterwards so back-to-back requests never toggle it.
	task automatic send_request(input cmd_t c, input logic [COORD_W-1:0] r,
			input logic [COORD_W-1:0] k);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= c;
		site_row <= r;
		site_col <= k;
		@(posedge clk);
		// in_stall read here is the value that held at this edge
		while (in_stall) @(posedge clk);
	endtask

	// Drop valid and wait until every predicted result has come back.
	// The first edge lets the checker count a request accepted just now.
	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (open_requests != 0) @(posedge clk);
	endtask

	// Write the target energy with the block idle.
	task automatic set_target(input int value);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value[E_W-1:0];
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	initial begin
		int   tgt;
		cmd_t c;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: high target so heat-up moves bite, corners for wrap-around.
		set_target(128);
		send_request(CMD_DEMON, 3'd0, 3'd0);  // demon empty, flip costs 8: reject
		send_request(CMD_HEAT,  3'd0, 3'd0);  // raise energy
		send_request(CMD_HEAT,  3'd0, 3'd0);  // would lower energy: hold
		send_request(CMD_HEAT,  3'd7, 3'd7);
		send_request(CMD_HEAT,  3'd0, 3'd7);  // zero energy change: hold
		send_request(CMD_HEAT,  3'd7, 3'd0);
		send_request(CMD_DEMON, 3'd0, 3'd0);  // demon gains energy
		send_request(CMD_DEMON, 3'd0, 3'd7);
		send_request(CMD_DEMON, 3'd7, 3'd7);
		send_request(CMD_DEMON, 3'd3, 3'd4);
		send_request(CMD_HEAT,  3'd3, 3'd4);
		send_request(CMD_DEMON, 3'd3, 3'd4);
		send_request(CMD_HEAT,  3'd3, 3'd5);
		send_request(CMD_DEMON, 3'd3, 3'd5);
		// Lowest target: energy is never below it, heat-up holds every spin.
		set_target(-128);
		send_request(CMD_HEAT,  3'd5, 3'd5);
		send_request(CMD_DEMON, 3'd5, 3'd5);
		set_target(-1);
		send_request(CMD_HEAT,  3'd6, 3'd2);
		send_request(CMD_HEAT,  3'd6, 3'd3);
		send_request(CMD_DEMON, 3'd2, 3'd6);

		// Random: heat the lattice early in each phase, then let the demon work.
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0:       tgt = 128;
				2:       tgt = -128;
				4:       tgt = 0;
				6:       tgt = -1;
				default: tgt = int'($urandom_range(256)) - 128;
			endcase
			set_target(tgt);
			case (ph % 4)
				0: begin
					send_gap_pct = 0;
					stall_pct    = 0;
				end
				1: begin
					send_gap_pct = 81;
					stall_pct    = 0;
				end
				2: begin
					send_gap_pct = 0;
					stall_pct    = 81;
				end
				default: begin
					send_gap_pct = 29;
					stall_pct    = 29;
				end
			endcase
			for (int n = 0; n < PHASE_REQS; n++) begin
				c = ($urandom_range(99) < ((n < 40) ? 60 : 10)) ? CMD_HEAT : CMD_DEMON;
				send_request(c, COORD_W'($urandom_range(7)), COORD_W'($urandom_range(7)));
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (fault_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#2ms;
		$display("FAIL");
		$finish;
	end

endmodule

// File: files.f
rtl/isdm_pkg.sv
rtl/isdm_lattice.sv
rtl/isdm_core.sv
rtl/isdm_stats.sv
rtl/ising_demon_spin_update.sv
rtl/isdm_chk.sv
dv/isdm_flip_checker.sv
dv/testbench.sv
